// File: rtl/core/dhls_pkg.sv
// ----------------------------------------------------------------------------
// Delayed hysteresis load switch package
// Shared widths, register and mode codes, and the payload and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package dhls_pkg;

	localparam int POWER_BITS    = 21;
	localparam int TIME_BITS     = 32;
	localparam int FRAC_BITS     = 16;
	localparam int COUNT_BITS    = 32;
	localparam int MODE_BITS     = 2;
	localparam int CFG_DATA_BITS = 32;
	localparam int CFG_IDX_BITS  = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_FRACTION  = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MODE      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_ON  = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_DELAY_OFF = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_ENABLE    = 3'd5;

	// Rule modes; the remaining codes are never met.
	localparam logic [MODE_BITS-1:0] MODE_ABOVE = 2'd0;
	localparam logic [MODE_BITS-1:0] MODE_BELOW = 2'd1;
	localparam logic [MODE_BITS-1:0] MODE_NEVER = 2'd2;

	typedef struct packed {
		logic signed [POWER_BITS-1:0] export_power;
		logic        [TIME_BITS-1:0]  now_ms;
		logic                         device_on;
	} in_item_t;

	typedef struct packed {
		logic                  command_valid;
		logic                  switch_on;
		logic                  condition_active;
		logic                  delay_pending;
		logic [COUNT_BITS-1:0] trigger_count;
	} out_item_t;

	// Configuration as seen by the rule core, with the hysteresis offset
	// already worked out from threshold and fraction.
	typedef struct packed {
		logic signed [POWER_BITS-1:0] threshold;
		logic signed [POWER_BITS-1:0] offset;
		logic        [MODE_BITS-1:0]  rule_mode;
		logic        [TIME_BITS-1:0]  delay_on;
		logic        [TIME_BITS-1:0]  delay_off;
		logic                         rule_enabled;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/dhls_cfg_regs.sv
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the rule registers and a registered hysteresis offset.
// ----------------------------------------------------------------------------
`default_nettype none

module dhls_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [dhls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [dhls_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	output dhls_pkg::cfg_t                           cfg
);
	import dhls_pkg::*;

	localparam int PROD_BITS = POWER_BITS + FRAC_BITS + 1;

	logic signed [POWER_BITS-1:0] threshold_q;
	logic        [FRAC_BITS-1:0]  fraction_q;
	logic        [MODE_BITS-1:0]  mode_q;
	logic        [TIME_BITS-1:0]  delay_on_q;
	logic        [TIME_BITS-1:0]  delay_off_q;
	logic                         enable_q;
	logic signed [POWER_BITS-1:0] offset_q;
	logic signed [PROD_BITS-1:0]  prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
			fraction_q  <= '0;
			mode_q      <= MODE_NEVER;
			delay_on_q  <= '0;
			delay_off_q <= '0;
			enable_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THRESHOLD: threshold_q <= cfg_wdata[POWER_BITS-1:0];
				REG_FRACTION:  fraction_q  <= cfg_wdata[FRAC_BITS-1:0];
				REG_MODE:      mode_q      <= cfg_wdata[MODE_BITS-1:0];
				REG_DELAY_ON:  delay_on_q  <= cfg_wdata[TIME_BITS-1:0];
				REG_DELAY_OFF: delay_off_q <= cfg_wdata[TIME_BITS-1:0];
				REG_ENABLE:    enable_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// The product is exact; taking the upper bits is a floor division by 2^16.
	assign prod = $signed({threshold_q[POWER_BITS-1], threshold_q})
		* $signed({1'b0, fraction_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
		end else begin
			offset_q <= prod[FRAC_BITS+POWER_BITS-1:FRAC_BITS];
		end
	end

	always_comb begin
		cfg.threshold    = threshold_q;
		cfg.offset       = offset_q;
		cfg.rule_mode    = mode_q;
		cfg.delay_on     = delay_on_q;
		cfg.delay_off    = delay_off_q;
		cfg.rule_enabled = enable_q;
	end

endmodule

`default_nettype wire

// File: rtl/core/dhls_rule_core.sv
// ----------------------------------------------------------------------------
// Rule core
// Rule state and the single-pass evaluation of one sample.
// ----------------------------------------------------------------------------
`default_nettype none

module dhls_rule_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               fire,
	input  wire dhls_pkg::in_item_t item,
	input  wire dhls_pkg::cfg_t     cfg,
	output dhls_pkg::out_item_t result,
	output logic [dhls_pkg::COUNT_BITS-1:0] trig_count
);
	import dhls_pkg::*;

	logic                  cond_q, wait_q;
	logic [TIME_BITS-1:0]  met_since_q, last_action_q;
	logic [COUNT_BITS-1:0] trig_q;

	logic                  cond_n, wait_n;
	logic [TIME_BITS-1:0]  met_since_n, last_action_n;
	logic [COUNT_BITS-1:0] trig_n;

	logic signed [POWER_BITS:0] eff;
	logic signed [POWER_BITS:0] power_x;
	logic                  met, want_on, acted, cmd, turn_on;
	logic [TIME_BITS-1:0]  need, elapsed, since;

	always_comb begin
		power_x = {item.export_power[POWER_BITS-1], item.export_power};
		if (item.device_on) begin
			eff = {cfg.threshold[POWER_BITS-1], cfg.threshold}
				- {cfg.offset[POWER_BITS-1], cfg.offset};
		end else begin
			eff = {cfg.threshold[POWER_BITS-1], cfg.threshold}
				+ {cfg.offset[POWER_BITS-1], cfg.offset};
		end
		case (cfg.rule_mode)
			MODE_ABOVE: met = power_x >= eff;
			MODE_BELOW: met = power_x <= eff;
			default:    met = 1'b0;
		endcase

		cond_n        = cond_q;
		wait_n        = wait_q;
		met_since_n   = met_since_q;
		last_action_n = last_action_q;
		trig_n        = trig_q;
		acted         = 1'b0;
		cmd           = 1'b0;
		turn_on       = 1'b0;
		want_on       = (cfg.rule_mode == MODE_ABOVE);
		need          = want_on ? cfg.delay_on : cfg.delay_off;

		if (cfg.rule_enabled) begin
			if (met && !cond_q) begin
				cond_n      = 1'b1;
				wait_n      = 1'b1;
				met_since_n = item.now_ms;
			end else if (!met && cond_q) begin
				cond_n = 1'b0;
				wait_n = 1'b0;
			end
		end

		elapsed = item.now_ms - met_since_n;
		since   = item.now_ms - last_action_q;

		if (cfg.rule_enabled) begin
			if (cond_n && wait_n && (elapsed >= need)) begin
				if (item.device_on != want_on) begin
					cmd     = 1'b1;
					turn_on = want_on;
				end
				wait_n        = 1'b0;
				last_action_n = item.now_ms;
				trig_n        = trig_q + 1'b1;
				acted         = 1'b1;
			end
			if (!acted && !cond_n && item.device_on && want_on
				&& (since >= cfg.delay_off)) begin
				cmd           = 1'b1;
				turn_on       = 1'b0;
				last_action_n = item.now_ms;
			end
		end

		result.command_valid    = cmd;
		result.switch_on        = cmd && turn_on;
		result.condition_active = cond_n;
		result.delay_pending    = cond_n && wait_n;
		result.trigger_count    = trig_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cond_q        <= 1'b0;
			wait_q        <= 1'b0;
			met_since_q   <= '0;
			last_action_q <= '0;
			trig_q        <= '0;
		end else if (fire) begin
			cond_q        <= cond_n;
			wait_q        <= wait_n;
			met_since_q   <= met_since_n;
			last_action_q <= last_action_n;
			trig_q        <= trig_n;
		end
	end

	assign trig_count = trig_q;

endmodule

`default_nettype wire

// File: rtl/core/delayed_hysteresis_load_switch_unit.sv
// ----------------------------------------------------------------------------
// Delayed hysteresis load switch unit
// One export-power rule with hysteresis, an on delay and an off delay.
// ----------------------------------------------------------------------------
//
//   Channel   Signals                          Moves
//   input     in_valid, in_ready, in_data      one power sample per transfer
//   output    out_valid, out_ready, out_data   one rule result per transfer
//   config    cfg_we, cfg_index, cfg_wdata     one register write per cycle
//
// A sample is held in the input register, and its result goes through the
// rule logic into the result register, from which it is offered on the
// output channel.
// A new sample is taken in every cycle while results drain.
// The hysteresis offset is registered in the cycle after a configuration write.
// Reset clears the rule state and loads the register defaults (mode never met).
// A stalled output holds the result and backs up into the input register.
//
`default_nettype none

module delayed_hysteresis_load_switch_unit (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire dhls_pkg::in_item_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output dhls_pkg::out_item_t                      out_data,
	input  wire logic                                cfg_we,
	input  wire logic [dhls_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [dhls_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);
	import dhls_pkg::*;

	cfg_t                  cfg;
	in_item_t              item_s1;
	logic                  valid_s1;
	out_item_t             res_s2;
	logic                  valid_s2;
	out_item_t             result;
	logic                  advance;
	logic                  fire;
	logic [COUNT_BITS-1:0] trig_count;

	dhls_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// The result register can take a new result when it is empty or its
	// current result is being transferred out in this cycle.
	assign advance  = !valid_s2 || out_ready;
	assign fire     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// The rule state is updated only when the sample's result is stored, so
	// the next sample always sees the state this one leaves.
	dhls_rule_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (fire),
		.item       (item_s1),
		.cfg        (cfg),
		.result     (result),
		.trig_count (trig_count)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

	// An empty result register never blocks the input side.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> in_ready)
		else $error("input stalled while the result register is empty");

	// A disabled rule never produces a switch command.
	a_disabled_no_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && !cfg.rule_enabled) |=> !res_s2.command_valid)
		else $error("command issued while the rule is disabled");

	// The trigger count advances by at most one per cycle.
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(trig_count == $past(trig_count)) || (trig_count == $past(trig_count) + 1'b1))
		else $error("trigger count jumped");

	// A stored result with a pending delay always has its condition met.
	a_pending_cond: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (!res_s2.delay_pending || res_s2.condition_active))
		else $error("delay pending without an active condition");

endmodule

`default_nettype wire

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// Delayed hysteresis load switch testbench
// Drives power samples and register writes into the switch unit, predicts
// every rule result in a model of its own and checks each output transfer
// against the oldest prediction, with random gaps on both channels.
// ----------------------------------------------------------------------------
module testbench;
	import dhls_pkg::*;

	localparam int P_MIN          = -(1 << (POWER_BITS - 1));
	localparam int P_MAX          = (1 << (POWER_BITS - 1)) - 1;
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_ITEMS   = 1900;
	localparam int PRINT_CAP      = 100;

	// Mode code 3 has no name in the package; like mode 2 it is never met.
	localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

	typedef enum logic {ROW_REG, ROW_SAMPLE} row_kind_t;

	typedef struct packed {
		row_kind_t                kind;
		logic [CFG_IDX_BITS-1:0]  reg_index;
		logic [CFG_DATA_BITS-1:0] reg_value;
		in_item_t                 sample;
		logic                     typed;
	} plan_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	in_item_t                 in_data;
	logic                     out_valid;
	logic                     out_ready;
	out_item_t                out_data;
	logic                     cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_wdata;

	delayed_hysteresis_load_switch_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always #5 clk = ~clk;

	// Shadow copy of the registers, kept in step with every write.
	logic signed [POWER_BITS-1:0] cfg_threshold;
	logic [FRAC_BITS-1:0]         cfg_fraction;
	logic [MODE_BITS-1:0]         cfg_mode;
	logic [TIME_BITS-1:0]         cfg_delay_on;
	logic [TIME_BITS-1:0]         cfg_delay_off;
	logic                         cfg_enable;

	// Rule state as the block should hold it.
	logic                  rule_met;
	logic                  rule_waiting;
	logic [TIME_BITS-1:0]  met_since;
	logic [TIME_BITS-1:0]  last_switch_ms;
	logic [COUNT_BITS-1:0] action_total;

	out_item_t   switch_results_due[$];
	out_item_t   last_prediction;
	plan_row_t   directed_plan[$];
	int unsigned mismatch_count;
	int unsigned quiet_cycles;
	bit          in_calm;
	bit          out_calm;

	// Hysteresis offset: exact product, then an arithmetic shift so that a
	// negative product rounds toward minus infinity.
	function automatic longint hyst_offset();
		return (longint'(cfg_threshold) * longint'(cfg_fraction)) >>> FRAC_BITS;
	endfunction

	// One step of the rule for an accepted sample; updates the shadow state.
	function automatic out_item_t switch_rule_step(input in_item_t s);
		out_item_t            r;
		longint               level;
		longint               power;
		logic                 met;
		logic                 acted;
		logic                 want_on;
		logic [TIME_BITS-1:0] need;
		logic [TIME_BITS-1:0] span_ms;
		r = '0;
		if (cfg_enable) begin
			power = longint'($signed(s.export_power));
			level = s.device_on ? longint'(cfg_threshold) - hyst_offset()
			                    : longint'(cfg_threshold) + hyst_offset();
			case (cfg_mode)
				MODE_ABOVE: met = power >= level;
				MODE_BELOW: met = power <= level;
				default:    met = 1'b0;
			endcase
			acted = 1'b0;
			if (met && !rule_met) begin
				rule_met     = 1'b1;
				rule_waiting = 1'b1;
				met_since    = s.now_ms;
			end else if (!met && rule_met) begin
				rule_met     = 1'b0;
				rule_waiting = 1'b0;
			end
			// The action delay runs on wrapping time differences.
			if (rule_met && rule_waiting) begin
				want_on = (cfg_mode == MODE_ABOVE);
				need    = want_on ? cfg_delay_on : cfg_delay_off;
				span_ms = s.now_ms - met_since;
				if (span_ms >= need) begin
					if (s.device_on != want_on) begin
						r.command_valid = 1'b1;
						r.switch_on     = want_on;
					end
					rule_waiting   = 1'b0;
					last_switch_ms = s.now_ms;
					action_total   = action_total + 1'b1;
					acted          = 1'b1;
				end
			end
			// Above mode turns the device back off once the condition is gone.
			if (!acted && !rule_met && s.device_on && cfg_mode == MODE_ABOVE) begin
				span_ms = s.now_ms - last_switch_ms;
				if (span_ms >= cfg_delay_off) begin
					r.command_valid = 1'b1;
					r.switch_on     = 1'b0;
					last_switch_ms  = s.now_ms;
				end
			end
		end
		r.condition_active = rule_met;
		r.delay_pending    = rule_met && rule_waiting;
		r.trigger_count    = action_total;
		return r;
	endfunction

	function automatic int unsigned pick_wait(input bit calm);
		return calm ? 0 : $urandom_range(0, 19);
	endfunction

	function automatic plan_row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx,
	                                      input logic [CFG_DATA_BITS-1:0] value);
		plan_row_t row;
		row           = '0;
		row.kind      = ROW_REG;
		row.reg_index = idx;
		row.reg_value = value;
		return row;
	endfunction

	function automatic plan_row_t sample_row(input int power, input logic [TIME_BITS-1:0] now,
	                                         input logic dev, input logic typed);
		plan_row_t row;
		row                     = '0;
		row.kind                = ROW_SAMPLE;
		row.sample.export_power = power[POWER_BITS-1:0];
		row.sample.now_ms       = now;
		row.sample.device_on    = dev;
		row.typed               = typed;
		return row;
	endfunction

	task automatic flag_mismatch(input string what, input logic [31:0] got,
	                             input logic [31:0] want);
		if (mismatch_count < PRINT_CAP)
			$display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
		mismatch_count++;
	endtask

	// Register write; the caller lowers cfg_we after the last write of a batch.
	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
	                         input logic [CFG_DATA_BITS-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		case (idx)
			REG_THRESHOLD: cfg_threshold = value[POWER_BITS-1:0];
			REG_FRACTION:  cfg_fraction  = value[FRAC_BITS-1:0];
			REG_MODE:      cfg_mode      = value[MODE_BITS-1:0];
			REG_DELAY_ON:  cfg_delay_on  = value[TIME_BITS-1:0];
			REG_DELAY_OFF: cfg_delay_off = value[TIME_BITS-1:0];
			REG_ENABLE:    cfg_enable    = value[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Registers change only with the pipeline empty: drain every result, then
	// give the two pipeline stages time to empty.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (switch_results_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Offers one sample and, on its transfer, records the result it must cause.
	// Called and returning at a falling edge.
	task automatic send_sample(input in_item_t s, input logic typed);
		int unsigned gap;
		out_item_t   predicted;
		out_item_t   blank;
		blank = '0;
		gap   = pick_wait(in_calm);
		if ($urandom_range(0, 49) == 0)
			in_calm = !in_calm;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = switch_rule_step(s);
		// Typed rows sit where the rule is off or cannot be met, so the whole
		// result must read zero.
		if (typed)
			switch_results_due = {switch_results_due, blank};
		else
			switch_results_due = {switch_results_due, predicted};
		last_prediction = predicted;
		@(negedge clk);
	endtask

	// Result side: a fresh stall before every transfer, with calm stretches.
	initial begin
		int unsigned stall;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			stall = pick_wait(out_calm);
			if ($urandom_range(0, 49) == 0)
				out_calm = !out_calm;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	// Every result transfer is compared field by field with the oldest prediction.
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (switch_results_due.size() == 0) begin
				flag_mismatch("result with none expected", out_data.trigger_count, 32'd0);
			end else begin
				want = switch_results_due.pop_front();
				if (out_data.command_valid !== want.command_valid)
					flag_mismatch("command_valid", out_data.command_valid, want.command_valid);
				if (out_data.switch_on !== want.switch_on)
					flag_mismatch("switch_on", out_data.switch_on, want.switch_on);
				if (out_data.condition_active !== want.condition_active)
					flag_mismatch("condition_active", out_data.condition_active,
					              want.condition_active);
				if (out_data.delay_pending !== want.delay_pending)
					flag_mismatch("delay_pending", out_data.delay_pending, want.delay_pending);
				if (out_data.trigger_count !== want.trigger_count)
					flag_mismatch("trigger_count", out_data.trigger_count, want.trigger_count);
			end
		end
	end

	// Watchdog: too many cycles in a row without any transfer or write.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d quiet cycles", quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		in_item_t             s;
		logic                 dev_state;
		logic [TIME_BITS-1:0] clock_ms;
		int unsigned          span;
		int unsigned          phase_items;
		int unsigned          random_items;
		longint               level;
		logic [TIME_BITS-1:0] delay_pick[2];

		arst_n         = 1'b0;
		in_valid       = 1'b0;
		in_data        = '0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		quiet_cycles   = 0;
		mismatch_count = 0;
		in_calm        = 1'b0;
		out_calm       = 1'b0;

		// Register and state values after reset.
		cfg_threshold  = '0;
		cfg_fraction   = '0;
		cfg_mode       = MODE_NEVER;
		cfg_delay_on   = '0;
		cfg_delay_off  = '0;
		cfg_enable     = 1'b0;
		rule_met       = 1'b0;
		rule_waiting   = 1'b0;
		met_since      = '0;
		last_switch_ms = '0;
		action_total   = '0;

		directed_plan = '{
			// Out of reset the rule is off, then on but in the never-met modes.
			sample_row(P_MAX, 32'd0, 1'b1, 1'b1),
			reg_row(REG_ENABLE, 32'd1),
			sample_row(P_MIN, 32'hFFFF_FFFF, 1'b0, 1'b1),
			reg_row(REG_MODE, MODE_SPARE),
			sample_row(0, 32'd5, 1'b1, 1'b1),
			// Above mode, threshold 1000 with a half offset of 500.
			reg_row(REG_THRESHOLD, 32'd1000),
			reg_row(REG_FRACTION, 32'h0000_8000),
			reg_row(REG_DELAY_ON, 32'd100),
			reg_row(REG_DELAY_OFF, 32'd50),
			reg_row(REG_MODE, MODE_ABOVE),
			sample_row(1499, 32'd1000, 1'b0, 1'b0),
			sample_row(1500, 32'd1000, 1'b0, 1'b0),
			sample_row(1500, 32'd1099, 1'b0, 1'b0),
			sample_row(1600, 32'd1100, 1'b0, 1'b0),
			sample_row(500, 32'd1200, 1'b1, 1'b0),
			sample_row(499, 32'd1120, 1'b1, 1'b0),
			sample_row(0, 32'd1150, 1'b1, 1'b0),
			// Delay done while the device is already on: counted, no command.
			reg_row(REG_DELAY_ON, 32'd0),
			sample_row(1500, 32'd1300, 1'b1, 1'b0),
			// On delay across the wrap of the millisecond counter.
			reg_row(REG_DELAY_ON, 32'd100),
			sample_row(400, 32'hFFFF_FFF0, 1'b1, 1'b0),
			sample_row(1500, 32'hFFFF_FFF8, 1'b0, 1'b0),
			sample_row(1500, 32'h0000_005B, 1'b0, 1'b0),
			sample_row(1500, 32'h0000_005C, 1'b0, 1'b0),
			// Below mode with a negative threshold and the largest fraction.
			reg_row(REG_THRESHOLD, 32'(-1000)),
			reg_row(REG_FRACTION, 32'h0000_FFFF),
			reg_row(REG_MODE, MODE_BELOW),
			reg_row(REG_DELAY_OFF, 32'd0),
			sample_row(0, 32'd10, 1'b1, 1'b0),
			sample_row(-1999, 32'd20, 1'b0, 1'b0),
			sample_row(-2000, 32'd30, 1'b0, 1'b0),
			// Most negative threshold and the longest delay, which a wrap ends.
			reg_row(REG_THRESHOLD, 32'(P_MIN)),
			reg_row(REG_DELAY_OFF, 32'hFFFF_FFFF),
			sample_row(P_MIN, 32'd40, 1'b0, 1'b0),
			sample_row(-16, 32'd50, 1'b1, 1'b0),
			sample_row(-16, 32'd49, 1'b1, 1'b0),
			// Largest threshold in above mode, then a pending delay frozen
			// while the rule is switched off.
			reg_row(REG_THRESHOLD, 32'(P_MAX)),
			reg_row(REG_MODE, MODE_ABOVE),
			reg_row(REG_DELAY_ON, 32'hFFFF_FFFF),
			reg_row(REG_DELAY_OFF, 32'd0),
			sample_row(P_MIN, 32'd55, 1'b0, 1'b0),
			sample_row(P_MAX, 32'd60, 1'b1, 1'b0),
			reg_row(REG_ENABLE, 32'd0),
			sample_row(P_MIN, 32'd70, 1'b0, 1'b0),
			reg_row(REG_ENABLE, 32'd1),
			sample_row(P_MIN, 32'd80, 1'b1, 1'b0)
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_plan[i]) begin
			if (directed_plan[i].kind == ROW_REG) begin
				if (!cfg_we)
					settle_block();
				write_reg(directed_plan[i].reg_index, directed_plan[i].reg_value);
			end else begin
				cfg_we <= 1'b0;
				send_sample(directed_plan[i].sample, directed_plan[i].typed);
			end
		end
		cfg_we <= 1'b0;

		// Random phases: a new setting each time, then a run of samples whose
		// power hovers around the live threshold, time mostly moving forward
		// and a device that mostly follows the commands it is sent.
		random_items = 0;
		dev_state    = 1'b0;
		while (random_items < RANDOM_ITEMS) begin
			settle_block();
			case ($urandom_range(0, 7))
				0:       write_reg(REG_THRESHOLD, 32'(P_MIN));
				1:       write_reg(REG_THRESHOLD, 32'(P_MAX));
				2:       write_reg(REG_THRESHOLD, 32'd0);
				3:       write_reg(REG_THRESHOLD, $urandom);
				default: write_reg(REG_THRESHOLD, 32'(int'($urandom_range(0, 4000)) - 2000));
			endcase
			case ($urandom_range(0, 3))
				0:       write_reg(REG_FRACTION, 32'd0);
				1:       write_reg(REG_FRACTION, 32'h0000_FFFF);
				default: write_reg(REG_FRACTION, $urandom_range(0, 65535));
			endcase
			case ($urandom_range(0, 9))
				0, 1, 2, 3: write_reg(REG_MODE, MODE_ABOVE);
				4, 5, 6, 7: write_reg(REG_MODE, MODE_BELOW);
				8:          write_reg(REG_MODE, MODE_NEVER);
				default:    write_reg(REG_MODE, MODE_SPARE);
			endcase
			foreach (delay_pick[k]) begin
				case ($urandom_range(0, 9))
					0:       delay_pick[k] = '0;
					1:       delay_pick[k] = '1;
					2:       delay_pick[k] = $urandom;
					default: delay_pick[k] = $urandom_range(0, 300);
				endcase
			end
			write_reg(REG_DELAY_ON, delay_pick[0]);
			write_reg(REG_DELAY_OFF, delay_pick[1]);
			write_reg(REG_ENABLE, ($urandom_range(0, 7) != 0) ? 32'd1 : 32'd0);
			cfg_we <= 1'b0;

			span        = $urandom_range(1, 80);
			clock_ms    = $urandom;
			phase_items = $urandom_range(40, 120);
			repeat (phase_items) begin
				if ($urandom_range(0, 29) == 0)
					clock_ms = $urandom;
				else
					clock_ms = clock_ms + $urandom_range(0, span);
				if ($urandom_range(0, 7) == 0) begin
					s.export_power = POWER_BITS'($urandom);
				end else begin
					level = dev_state ? longint'(cfg_threshold) - hyst_offset()
					                  : longint'(cfg_threshold) + hyst_offset();
					level = level + int'($urandom_range(0, 64)) - 32;
					if (level > P_MAX)
						level = P_MAX;
					if (level < P_MIN)
						level = P_MIN;
					s.export_power = level[POWER_BITS-1:0];
				end
				s.now_ms    = clock_ms;
				s.device_on = dev_state;
				send_sample(s, 1'b0);
				random_items++;
				// The device follows a command, with a stray flip now and then.
				if (last_prediction.command_valid)
					dev_state = last_prediction.switch_on;
				if ($urandom_range(0, 15) == 0)
					dev_state = !dev_state;
			end
		end

		in_valid <= 1'b0;
		while (switch_results_due.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: sim.f
rtl/core/dhls_pkg.sv
rtl/core/dhls_cfg_regs.sv
rtl/core/dhls_rule_core.sv
rtl/core/delayed_hysteresis_load_switch_unit.sv
dv/testbench.sv
